// File: rtl/core/link_setup_ua_handshake_defines.svh
// Assertion macros shared by the checker files of the UA link setup block.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef LINK_SETUP_UA_HANDSHAKE_DEFINES_SVH
`define LINK_SETUP_UA_HANDSHAKE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSUH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LSUH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/lsuh_pkg.sv
// Shared types, codes and helper functions of the UA link setup block.
// Depends on nothing; used by every module of the block.
package lsuh_pkg;

  localparam int TIMER_BITS = 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] REG_FLAG_BYTE     = 3'd0;
  localparam logic [2:0] REG_REPLY_ADDRESS = 3'd1;
  localparam logic [2:0] REG_UA_CONTROL    = 3'd2;
  localparam logic [2:0] REG_RETRY_LIMIT   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd4;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] STATUS_IDLE = 2'd0;
  localparam logic [1:0] STATUS_WAIT = 2'd1;
  localparam logic [1:0] STATUS_CONN = 2'd2;
  localparam logic [1:0] STATUS_FAIL = 2'd3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [5:0] {
    FS_START = 6'b000001,
    FS_FLAG  = 6'b000010,
    FS_ADDR  = 6'b000100,
    FS_CTRL  = 6'b001000,
    FS_BCC   = 6'b010000,
    FS_STOP  = 6'b100000
  } frame_state_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       send_set;
    logic [1:0] link_status;
    logic [7:0] retries_used;
  } result_t;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [7:0]  reply_address;
    logic [7:0]  ua_control;
    logic [7:0]  retry_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] ticks);
    logic [32:0] wide;
    wide = 33'(ticks);
    if (wide > 33'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_BITS'(wide);
  endfunction

endpackage

// File: rtl/core/lsuh_cfg_regs.sv
// Configuration register file of the UA link setup block, APB-style port.
// Depends on lsuh_pkg for the register indexes and the configuration struct.
module lsuh_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsuh_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lsuh_pkg::DATA_BITS-1:0] pwdata,
  output logic [lsuh_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output lsuh_pkg::cfg_t                 cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte     <= 8'd126;
      cfg.reply_address <= 8'd3;
      cfg.ua_control    <= 8'd7;
      cfg.retry_limit   <= 8'd3;
      cfg.timeout_ticks <= 16'd3;
    end else if (wr_en) begin
      unique case (index)
        lsuh_pkg::REG_FLAG_BYTE:     cfg.flag_byte     <= pwdata[7:0];
        lsuh_pkg::REG_REPLY_ADDRESS: cfg.reply_address <= pwdata[7:0];
        lsuh_pkg::REG_UA_CONTROL:    cfg.ua_control    <= pwdata[7:0];
        lsuh_pkg::REG_RETRY_LIMIT:   cfg.retry_limit   <= pwdata[7:0];
        lsuh_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (index)
      lsuh_pkg::REG_FLAG_BYTE:     prdata = 32'(cfg.flag_byte);
      lsuh_pkg::REG_REPLY_ADDRESS: prdata = 32'(cfg.reply_address);
      lsuh_pkg::REG_UA_CONTROL:    prdata = 32'(cfg.ua_control);
      lsuh_pkg::REG_RETRY_LIMIT:   prdata = 32'(cfg.retry_limit);
      lsuh_pkg::REG_TIMEOUT_TICKS: prdata = 32'(cfg.timeout_ticks);
      default:                     prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/lsuh_frame_rec.sv
// Next-state logic of the UA frame recogniser: flag, address, control, check, flag.
// Depends on lsuh_pkg for the frame state type and the configuration struct.
module lsuh_frame_rec (
  input  lsuh_pkg::frame_state_t state,
  input  logic [7:0]             rx_byte,
  input  lsuh_pkg::cfg_t         cfg,
  output lsuh_pkg::frame_state_t state_next
);

  logic [7:0] check_byte;
  logic       is_flag;

  assign check_byte = cfg.ua_control ^ cfg.reply_address;
  assign is_flag    = (rx_byte == cfg.flag_byte);

  always_comb begin
    unique case (state)
      lsuh_pkg::FS_START: begin
        state_next = is_flag ? lsuh_pkg::FS_FLAG : lsuh_pkg::FS_START;
      end
      lsuh_pkg::FS_FLAG: begin
        state_next = (rx_byte == cfg.reply_address) ? lsuh_pkg::FS_ADDR : lsuh_pkg::FS_START;
      end
      lsuh_pkg::FS_ADDR: begin
        if (is_flag) begin
          state_next = lsuh_pkg::FS_FLAG;
        end else if (rx_byte == cfg.ua_control) begin
          state_next = lsuh_pkg::FS_CTRL;
        end else begin
          state_next = lsuh_pkg::FS_START;
        end
      end
      lsuh_pkg::FS_CTRL: begin
        // The check byte is tested before the flag.
        if (rx_byte == check_byte) begin
          state_next = lsuh_pkg::FS_BCC;
        end else if (is_flag) begin
          state_next = lsuh_pkg::FS_FLAG;
        end else begin
          state_next = lsuh_pkg::FS_START;
        end
      end
      lsuh_pkg::FS_BCC: begin
        state_next = is_flag ? lsuh_pkg::FS_STOP : lsuh_pkg::FS_START;
      end
      lsuh_pkg::FS_STOP: begin
        state_next = lsuh_pkg::FS_STOP;
      end
      default: begin
        state_next = lsuh_pkg::FS_START;
      end
    endcase
  end

endmodule

// File: rtl/core/lsuh_link_ctrl.sv
// Link state, wait timer, retry counter and result register of the UA link setup.
// Depends on lsuh_pkg and instantiates lsuh_frame_rec.
module lsuh_link_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  lsuh_pkg::item_t   item,
  input  lsuh_pkg::cfg_t    cfg,
  input  logic              result_ready,
  output logic              result_valid,
  output lsuh_pkg::result_t result
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_CONN = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_t;

  lsuh_pkg::frame_state_t              frame_state;
  lsuh_pkg::frame_state_t              frame_state_next;
  lsuh_pkg::frame_state_t              rec_next;
  logic [lsuh_pkg::TIMER_BITS-1:0]     wait_timer;
  logic [lsuh_pkg::TIMER_BITS-1:0]     wait_timer_next;
  logic [7:0]                          retry_count;
  logic [7:0]                          retry_count_next;
  logic [7:0]                          count_inc;
  phase_t                              link_phase;
  phase_t                              link_phase_next;
  logic                                send;
  logic [1:0]                          status;

  lsuh_frame_rec u_frame_rec (
    .state      (frame_state),
    .rx_byte    (item.rx_byte),
    .cfg        (cfg),
    .state_next (rec_next)
  );

  assign count_inc = (retry_count == lsuh_pkg::COUNT_MAX) ? retry_count : retry_count + 8'd1;

  always_comb begin
    frame_state_next = frame_state;
    wait_timer_next  = wait_timer;
    retry_count_next = retry_count;
    link_phase_next  = link_phase;
    send             = 1'b0;
    case (item.op)
      lsuh_pkg::OP_START: begin
        send             = 1'b1;
        retry_count_next = '0;
        frame_state_next = lsuh_pkg::FS_START;
        wait_timer_next  = lsuh_pkg::timer_load(cfg.timeout_ticks);
        link_phase_next  = PH_WAIT;
      end
      lsuh_pkg::OP_BYTE: begin
        if (link_phase == PH_WAIT) begin
          frame_state_next = rec_next;
          if (rec_next == lsuh_pkg::FS_STOP) begin
            link_phase_next = PH_CONN;
            wait_timer_next = '0;
          end
        end
      end
      lsuh_pkg::OP_TICK: begin
        if (link_phase == PH_WAIT) begin
          if (wait_timer > lsuh_pkg::TIMER_BITS'(1)) begin
            wait_timer_next = wait_timer - lsuh_pkg::TIMER_BITS'(1);
          end else begin
            retry_count_next = count_inc;
            if (count_inc <= cfg.retry_limit) begin
              send            = 1'b1;
              wait_timer_next = lsuh_pkg::timer_load(cfg.timeout_ticks);
            end else begin
              wait_timer_next = '0;
              link_phase_next = PH_FAIL;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (link_phase_next)
      PH_IDLE: status = lsuh_pkg::STATUS_IDLE;
      PH_WAIT: status = lsuh_pkg::STATUS_WAIT;
      PH_CONN: status = lsuh_pkg::STATUS_CONN;
      PH_FAIL: status = lsuh_pkg::STATUS_FAIL;
      default: status = lsuh_pkg::STATUS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state  <= lsuh_pkg::FS_START;
      wait_timer   <= '0;
      retry_count  <= '0;
      link_phase   <= PH_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        frame_state  <= frame_state_next;
        wait_timer   <= wait_timer_next;
        retry_count  <= retry_count_next;
        link_phase   <= link_phase_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.send_set     <= send;
      result.link_status  <= status;
      result.retries_used <= retry_count_next;
    end
  end

endmodule

// File: rtl/core/link_setup_ua_handshake.sv
// UA link setup block: emitter side of an HDLC-like SET/UA handshake with retry.
// An item is captured in an input register, and its state update is written to the
// result register at the clock edge on which the held item advances, which waits
// while a result is offered and not taken; one transaction is accepted per cycle
// when the result side keeps up, as the link state registers update at each advance.
// Depends on lsuh_pkg; instantiates lsuh_cfg_regs and lsuh_link_ctrl.
module link_setup_ua_handshake (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsuh_pkg::ADDR_BITS-1:0] paddr,
  input  logic [lsuh_pkg::DATA_BITS-1:0] pwdata,
  output logic [lsuh_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  lsuh_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output lsuh_pkg::result_t              result
);

  lsuh_pkg::cfg_t  cfg;
  lsuh_pkg::item_t held_item;
  logic            held_valid;
  logic            advance;

  lsuh_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held_item <= item;
    end
  end

  lsuh_link_ctrl u_link_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (held_item),
    .cfg          (cfg),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: rtl/core/lsuh_checker.sv
// Port-level checker of the UA link setup block, bound to the top level.
// Depends on lsuh_pkg and on the assertion macros of the block's header.
`include "link_setup_ua_handshake_defines.svh"

module lsuh_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input lsuh_pkg::result_t result
);

  `LSUH_ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid && $stable(result))
  `LSUH_ASSERT_IMPLY(a_empty_after_reset, clk, rst, $past(rst), !result_valid)
  `LSUH_ASSERT_IMPLY(a_send_only_waiting, clk, rst, result_valid && result.send_set, result.link_status == lsuh_pkg::STATUS_WAIT)
  `LSUH_ASSERT_IMPLY(a_idle_no_retries, clk, rst, result_valid && (result.link_status == lsuh_pkg::STATUS_IDLE), (result.retries_used == 8'd0) && !result.send_set)

endmodule

bind link_setup_ua_handshake lsuh_checker u_lsuh_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// File: verif/link_setup_ua_handshake_tb.sv
// Testbench for link_setup_ua_handshake: sends start, byte, tick and unused-op items with
// random gaps on both channels, checking every result against an in-bench link setup model.
// Depends on lsuh_pkg and the RTL of link_setup_ua_handshake only.
module link_setup_ua_handshake_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsuh_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1100;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;

  cfg_t                  cfg;
  frame_state_t          ua_state;
  logic [TIMER_BITS-1:0] wait_ticks;
  logic [7:0]            timeouts_seen;
  logic [1:0]            phase_now;

  result_t status_due[$];
  int      items_sent = 0;
  int      errors = 0;
  int      quiet_cycles = 0;
  bit      no_gaps = 1'b0;
  bit      hold_results = 1'b0;

  link_setup_ua_handshake u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TIMER_BITS-1:0] reload_ticks();
    if (32'(cfg.timeout_ticks) > 32'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_BITS'(cfg.timeout_ticks);
  endfunction

  function automatic frame_state_t ua_next(frame_state_t s, logic [7:0] b);
    case (s)
      FS_START: return (b == cfg.flag_byte) ? FS_FLAG : FS_START;
      FS_FLAG:  return (b == cfg.reply_address) ? FS_ADDR : FS_START;
      FS_ADDR: begin
        if (b == cfg.flag_byte) return FS_FLAG;
        if (b == cfg.ua_control) return FS_CTRL;
        return FS_START;
      end
      FS_CTRL: begin
        if (b == (cfg.ua_control ^ cfg.reply_address)) return FS_BCC;
        if (b == cfg.flag_byte) return FS_FLAG;
        return FS_START;
      end
      FS_BCC:   return (b == cfg.flag_byte) ? FS_STOP : FS_START;
      default:  return s;
    endcase
  endfunction

  function automatic result_t advance_link(item_t it);
    result_t r;
    r.send_set = 1'b0;
    case (it.op)
      OP_START: begin
        r.send_set    = 1'b1;
        timeouts_seen = '0;
        ua_state      = FS_START;
        wait_ticks    = reload_ticks();
        phase_now     = STATUS_WAIT;
      end
      OP_BYTE: begin
        if (phase_now == STATUS_WAIT) begin
          ua_state = ua_next(ua_state, it.rx_byte);
          if (ua_state == FS_STOP) begin
            phase_now  = STATUS_CONN;
            wait_ticks = '0;
          end
        end
      end
      OP_TICK: begin
        if (phase_now == STATUS_WAIT) begin
          if (wait_ticks > 1) begin
            wait_ticks = wait_ticks - 1'b1;
          end else begin
            wait_ticks = '0;
            if (timeouts_seen != COUNT_MAX) timeouts_seen = timeouts_seen + 1'b1;
            if (timeouts_seen <= cfg.retry_limit) begin
              r.send_set = 1'b1;
              wait_ticks = reload_ticks();
            end else begin
              phase_now = STATUS_FAIL;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.link_status  = phase_now;
    r.retries_used = timeouts_seen;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    int    gap;
    item_t it;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    it.op = op;
    it.rx_byte = b;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    status_due.push_back(advance_link(it));
    items_sent++;
  endtask

  task automatic send_reply_frame(input bit corrupt);
    logic [7:0] frame[5];
    frame = '{cfg.flag_byte, cfg.reply_address, cfg.ua_control,
              cfg.ua_control ^ cfg.reply_address, cfg.flag_byte};
    if (corrupt) frame[$urandom_range(0, 4)] = 8'($urandom);
    foreach (frame[i]) send_item(OP_BYTE, frame[i]);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_FLAG_BYTE:     cfg.flag_byte     = val[7:0];
      REG_REPLY_ADDRESS: cfg.reply_address = val[7:0];
      REG_UA_CONTROL:    cfg.ua_control    = val[7:0];
      REG_RETRY_LIMIT:   cfg.retry_limit   = val[7:0];
      REG_TIMEOUT_TICKS: cfg.timeout_ticks = val[15:0];
      default: begin
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] flag, input logic [7:0] addr,
                            input logic [7:0] ctrl, input logic [7:0] limit,
                            input logic [15:0] ticks);
    wait_drained();
    write_reg(REG_FLAG_BYTE, 32'(flag));
    write_reg(REG_REPLY_ADDRESS, 32'(addr));
    write_reg(REG_UA_CONTROL, 32'(ctrl));
    write_reg(REG_RETRY_LIMIT, 32'(limit));
    write_reg(REG_TIMEOUT_TICKS, 32'(ticks));
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic test_ignored_when_idle();
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_UNUSED, 8'hA5);
  endtask

  task automatic test_default_connect();
    send_item(OP_START, 8'h00);
    send_reply_frame(1'b0);
    send_item(OP_TICK, 8'h5A);
    send_item(OP_BYTE, cfg.flag_byte);
  endtask

  task automatic test_recogniser_across_retry();
    set_config(8'h7E, 8'h03, 8'h07, 8'd1, 16'd1);
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, cfg.flag_byte);
    send_item(OP_BYTE, cfg.reply_address);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, cfg.ua_control);
    send_item(OP_BYTE, cfg.ua_control ^ cfg.reply_address);
    send_item(OP_BYTE, cfg.flag_byte);
  endtask

  task automatic test_retry_exhaustion();
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'h00);
  endtask

  task automatic test_extreme_config();
    // The check byte of this frame equals the flag, and a zero timeout expires at once.
    set_config(8'h00, 8'hFF, 8'hFF, 8'd0, 16'd0);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'h00);
    send_reply_frame(1'b0);
    set_config(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'hFF);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_results = 1'b1;
    no_gaps = 1'b1;
    repeat (40) send_item(2'($urandom_range(0, 3)), 8'($urandom));
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_retry_saturation();
    set_config(cfg.flag_byte, cfg.reply_address, cfg.ua_control, 8'hFF, 16'd1);
    send_item(OP_START, 8'h00);
    repeat (300) begin
      send_item(($urandom_range(0, 9) == 0) ? OP_UNUSED : OP_TICK, 8'($urandom));
    end
  endtask

  task automatic test_random_phase(input int n);
    int         stop_at;
    int         pick;
    logic [7:0] limit;
    logic [15:0] ticks;
    case ($urandom_range(0, 5))
      0:       limit = 8'd0;
      1:       limit = 8'hFF;
      default: limit = 8'($urandom_range(0, 4));
    endcase
    case ($urandom_range(0, 7))
      0:       ticks = 16'd0;
      1:       ticks = 16'd1;
      2:       ticks = 16'hFFFF;
      default: ticks = 16'($urandom_range(1, 8));
    endcase
    set_config(pick_byte(), pick_byte(), pick_byte(), limit, ticks);
    no_gaps = ($urandom_range(0, 3) == 0);
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(OP_START, 8'($urandom));
      end else if (pick < 50) begin
        send_reply_frame($urandom_range(0, 3) == 0);
      end else if (pick < 75) begin
        send_item(OP_TICK, 8'($urandom));
      end else if (pick < 95) begin
        send_item(OP_BYTE, 8'($urandom));
      end else begin
        send_item(OP_UNUSED, 8'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin : result_side
    int stall;
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 18);
        if (stall > 0) begin
          result_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (status_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, result);
        end else begin
          want = status_due.pop_front();
          check_field("send_set", 8'(want.send_set), 8'(result.send_set));
          check_field("link_status", 8'(want.link_status), 8'(result.link_status));
          check_field("retries_used", want.retries_used, result.retries_used);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("** link_setup_ua_handshake: FAILED **");
    $finish;
  end

  initial begin
    cfg = '{flag_byte: 8'd126, reply_address: 8'd3, ua_control: 8'd7,
            retry_limit: 8'd3, timeout_ticks: 16'd3};
    ua_state      = FS_START;
    wait_ticks    = '0;
    timeouts_seen = '0;
    phase_now     = STATUS_IDLE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ignored_when_idle();
    test_default_connect();
    test_recogniser_across_retry();
    test_retry_exhaustion();
    test_extreme_config();
    test_backpressure();
    test_retry_saturation();
    while (items_sent < ITEM_TARGET) test_random_phase(130);
    wait_drained();
    if (errors == 0) begin
      $display("** link_setup_ua_handshake: PASSED **");
    end else begin
      $display("** link_setup_ua_handshake: FAILED **");
    end
    $finish;
  end

endmodule
